// ===== src/dnt_pkg.sv =====
// Shared types and constants for the day/night terminator pixel mask.
package dnt_pkg;

   // configuration register indexes
   typedef enum logic [2:0] {
      REG_SUN_LON  = 3'd0,
      REG_SUN_DECL = 3'd1,
      REG_WEST     = 3'd2,
      REG_LON_STEP = 3'd3,
      REG_NORTH    = 3'd4,
      REG_LAT_STEP = 3'd5
   } reg_index_type;

   localparam logic [15:0] SUN_LON_RESET  = 16'd0;
   localparam logic [15:0] SUN_DECL_RESET = 16'd0;
   localparam logic [15:0] WEST_RESET     = 16'd11286;
   localparam logic [15:0] LON_STEP_RESET = 16'd4206;
   localparam logic [15:0] NORTH_RESET    = 16'hE16D;   // -7827
   localparam logic [15:0] LAT_STEP_RESET = 16'd3262;

   localparam logic [15:0] QUARTER = 16'd16384;

   // quarter-wave polynomial coefficients
   localparam logic [12:0] SIN_K1    = 13'd4639;
   localparam logic [15:0] SIN_K2    = 16'd42047;
   localparam logic [16:0] SIN_K3    = 17'd102944;
   localparam logic [15:0] SIN_RATIO = 16'd65535;

   // per-pixel payload carried alongside the arithmetic
   typedef struct packed {
      logic       map_bit;
      logic [7:0] day_pixel;
      logic [7:0] night_pixel;
   } side_type;

endpackage

// ===== src/dnt_sine.sv =====
// Six-stage pipelined table-free sine unit, output scaled to +/-65535.
module dnt_sine (
   input  logic               clock,
   input  logic               en,
   input  logic [15:0]        angle,
   output logic signed [16:0] value
);

   logic [1:0]  q;
   logic [13:0] xr;
   logic [14:0] x1_in, x1_ff, x2_ff, x3_ff;
   logic [29:0] sq_in, sq_ff;
   logic [14:0] z2_in, z2_ff;
   logic [26:0] m1_in, m1_ff;
   logic [15:0] t1_in;
   logic [29:0] m2_in, m2_ff;
   logic [16:0] t2_in;
   logic [31:0] m3_in, m3_ff;
   logic [17:0] s_in;
   logic [33:0] m4_in, m4_ff;
   logic [17:0] p;
   logic [15:0] pc;
   logic signed [16:0] value_in, value_ff;
   logic [4:0]  neg_ff;

   assign q  = angle[15:14];
   assign xr = angle[13:0];

   always_comb begin
      x1_in    = q[0] ? 15'(dnt_pkg::QUARTER - {2'b00, xr}) : {1'b0, xr};
      sq_in    = 30'(x1_in * x1_in);
      z2_in    = 15'(sq_ff >> 14);
      m1_in    = 27'(z2_in * dnt_pkg::SIN_K1);
      t1_in    = dnt_pkg::SIN_K2 - 16'(m1_ff >> 14);
      m2_in    = 30'(z2_ff * t1_in);
      t2_in    = dnt_pkg::SIN_K3 - 17'(m2_ff >> 14);
      m3_in    = 32'(x3_ff * t2_in);
      s_in     = 18'(m3_ff >> 14);
      m4_in    = 34'(s_in * dnt_pkg::SIN_RATIO);
      p        = m4_ff[33:16];
      pc       = (p > 18'(dnt_pkg::SIN_RATIO)) ? dnt_pkg::SIN_RATIO : p[15:0];
      value_in = neg_ff[4] ? -$signed({1'b0, pc}) : $signed({1'b0, pc});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff    <= x1_in;
         sq_ff    <= sq_in;
         x2_ff    <= x1_ff;
         z2_ff    <= z2_in;
         m1_ff    <= m1_in;
         x3_ff    <= x2_ff;
         m2_ff    <= m2_in;
         m3_ff    <= m3_in;
         m4_ff    <= m4_in;
         value_ff <= value_in;
         neg_ff   <= {neg_ff[3:0], q[1]};
      end
   end

   assign value = value_ff;

endmodule

// ===== src/dnt_elev.sv =====
// Four-stage elevation sign test: sd*sl*65535 + cd*cl*ch < 0.
module dnt_elev (
   input  logic               clock,
   input  logic               en,
   input  logic signed [16:0] sd,
   input  logic signed [16:0] cd,
   input  logic signed [16:0] sl,
   input  logic signed [16:0] cl,
   input  logic signed [16:0] ch,
   output logic               night
);

   logic signed [33:0] a_in, a_ff, b_in, b_ff;
   logic signed [16:0] ch_ff;
   logic signed [51:0] ae;
   logic signed [51:0] aa_in, aa_ff, aa2_ff;
   logic signed [34:0] pl_in, pl_ff, ph_in, ph_ff;
   logic signed [51:0] bb_in, bb_ff;
   logic signed [51:0] sum;
   logic               night_in, night_ff;

   always_comb begin
      a_in  = sd * sl;
      b_in  = cd * cl;
      ae    = 52'(a_ff);
      aa_in = (ae <<< 16) - ae;
      // split the wide product into two narrow ones
      pl_in = 35'($signed({1'b0, b_ff[15:0]}) * ch_ff);
      ph_in = 35'($signed(b_ff[33:16]) * ch_ff);
      bb_in = (52'(ph_ff) <<< 16) + 52'(pl_ff);
      sum   = aa2_ff + bb_ff;
      night_in = sum[51];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff     <= a_in;
         b_ff     <= b_in;
         ch_ff    <= ch;
         aa_ff    <= aa_in;
         pl_ff    <= pl_in;
         ph_ff    <= ph_in;
         aa2_ff   <= aa_ff;
         bb_ff    <= bb_in;
         night_ff <= night_in;
      end
   end

   assign night = night_ff;

endmodule

// ===== src/day_night_terminator_pixel_mask.sv =====
// Top level of the day/night terminator pixel mask pipeline.
//
//  channel | direction | ports                          | beat contents
//  req     | in        | req_tvalid/tready/tdata        | one map pixel
//  rsp     | out       | rsp_tvalid/tready/tdata        | night, mono bit, colour
//  csr     | in        | csr_valid/ready/index/data     | one register write
//
// One pixel per clock sustained while rsp beats are not stalled; the pipeline depth is set
// by the five parallel six-stage sine units and the split wide product in the elevation test.
// Synchronous active-high reset clears the valid line and loads register defaults.
// A stalled rsp beat freezes the whole pipeline; req_tready drops in the same cycle.
// csr_ready is always high; writes go straight to the registers.
module day_night_terminator_pixel_mask #(
   parameter int MAP_COLS = 144,
   parameter int MAP_ROWS = 100,
   localparam int COL_W = $clog2(MAP_COLS),
   localparam int ROW_W = $clog2(MAP_ROWS),
   localparam int REQ_W = ((COL_W + ROW_W + 17 + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // col, row, map_bit, day_pixel, night_pixel (lowest first), zero padded
   input  logic [REQ_W-1:0]  req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // night, mono_bit, color_pixel (lowest first), zero padded
   output logic [15:0]       rsp_tdata,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_data
);

   localparam int LAT   = 12;

   // config registers
   logic [15:0] sun_lon_ff, sun_decl_ff, west_ff, lon_step_ff, north_ff, lat_step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sun_lon_ff  <= dnt_pkg::SUN_LON_RESET;
         sun_decl_ff <= dnt_pkg::SUN_DECL_RESET;
         west_ff     <= dnt_pkg::WEST_RESET;
         lon_step_ff <= dnt_pkg::LON_STEP_RESET;
         north_ff    <= dnt_pkg::NORTH_RESET;
         lat_step_ff <= dnt_pkg::LAT_STEP_RESET;
      end else if (csr_valid) begin
         case (dnt_pkg::reg_index_type'(csr_index))
            dnt_pkg::REG_SUN_LON:  sun_lon_ff  <= csr_data;
            dnt_pkg::REG_SUN_DECL: sun_decl_ff <= csr_data;
            dnt_pkg::REG_WEST:     west_ff     <= csr_data;
            dnt_pkg::REG_LON_STEP: lon_step_ff <= csr_data;
            dnt_pkg::REG_NORTH:    north_ff    <= csr_data;
            dnt_pkg::REG_LAT_STEP: lat_step_ff <= csr_data;
            default: ;  // unknown index ignored
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // global advance: whole pipe moves unless the output beat is stuck
   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // unpack request beat
   logic [COL_W-1:0] col;
   logic [ROW_W-1:0] row;
   dnt_pkg::side_type side_in;

   assign col = req_tdata[COL_W-1:0];
   assign row = req_tdata[COL_W +: ROW_W];
   assign side_in.map_bit     = req_tdata[COL_W + ROW_W];
   assign side_in.day_pixel   = req_tdata[COL_W + ROW_W + 1 +: 8];
   assign side_in.night_pixel = req_tdata[COL_W + ROW_W + 9 +: 8];

   // stage 1: column/row scaling products
   logic [COL_W+15:0] p_lon_in, p_lon_ff;
   logic [ROW_W+15:0] p_lat_in, p_lat_ff;
   // stage 2: latitude and hour angles
   logic [15:0] lon, lat_in, lat_ff, hour_in, hour_ff;

   always_comb begin
      p_lon_in = (COL_W + 16)'(col * lon_step_ff);
      p_lat_in = (ROW_W + 16)'(row * lat_step_ff);
      // drop the eight fraction bits, keep the angle modulo a full circle
      lon      = west_ff + 16'(p_lon_ff >> 8);
      lat_in   = north_ff + 16'(p_lat_ff >> 8);
      hour_in  = sun_lon_ff - lon;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_lon_ff <= p_lon_in;
         p_lat_ff <= p_lat_in;
         lat_ff   <= lat_in;
         hour_ff  <= hour_in;
      end
   end

   // valid bits and pixel payload travel alongside the arithmetic
   logic [LAT-1:0]    v_ff;
   dnt_pkg::side_type side_ff [LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[LAT-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // sine and cosine of declination, latitude and hour angle
   logic signed [16:0] sd, cd, sl, cl, ch;

   dnt_sine u_sd (.clock(clock), .en(en), .angle(sun_decl_ff), .value(sd));
   dnt_sine u_cd (.clock(clock), .en(en), .angle(sun_decl_ff + dnt_pkg::QUARTER), .value(cd));
   dnt_sine u_sl (.clock(clock), .en(en), .angle(lat_ff), .value(sl));
   dnt_sine u_cl (.clock(clock), .en(en), .angle(lat_ff + dnt_pkg::QUARTER), .value(cl));
   dnt_sine u_ch (.clock(clock), .en(en), .angle(hour_ff + dnt_pkg::QUARTER), .value(ch));

   logic night;

   dnt_elev u_elev (
      .clock(clock), .en(en),
      .sd(sd), .cd(cd), .sl(sl), .cl(cl), .ch(ch),
      .night(night)
   );

   // result beat
   assign rsp_tvalid = v_ff[LAT-1];
   assign rsp_tdata  = {6'd0,
                        night ? side_ff[LAT-1].night_pixel : side_ff[LAT-1].day_pixel,
                        night ^ side_ff[LAT-1].map_bit,
                        night};

   // pipeline checks
   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(v_ff)) else $error("valid line moved during stall");
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> v_ff[0]) else $error("accepted pixel lost");
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      !req_tvalid && en |=> !v_ff[0]) else $error("pixel invented");

endmodule

// ===== dv/tb_day_night_terminator_pixel_mask.sv =====
// Testbench for the day/night terminator pixel mask, checked against a predictor.
`timescale 1ns / 100ps

module tb_day_night_terminator_pixel_mask;

   // csr indexes beyond the register file; writes there must change nothing
   localparam logic [2:0] SPARE_INDEX_A = 3'd6;
   localparam logic [2:0] SPARE_INDEX_B = 3'd7;
   localparam longint     TRIG_ONE      = 65535;
   localparam int         STALL_LIMIT   = 20000;

   typedef struct {
      logic [7:0] col;
      logic [6:0] row;
      logic       map_bit;
      logic [7:0] day_pixel;
      logic [7:0] night_pixel;
   } pixel_type;

   typedef struct {
      logic       night;
      logic       mono_bit;
      logic [7:0] color_pixel;
   } shade_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   // predictor copy of the register file
   logic [15:0] sun_lon, sun_decl, west, lon_step, north, lat_step;

   shade_type shade_queue[$];
   int     fail_count = 0;
   int     burst_left = 0;
   int     hold_off_cycles = 0;
   int     idle_cycles = 0;

   day_night_terminator_pixel_mask dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor
   // quarter-wave polynomial, x in 0..16384, result 0..65535
   function automatic longint quarter_sine(longint x);
      longint z2, t, s, p;
      z2 = (x * x) >>> 14;
      t  = 42047 - ((4639 * z2) >>> 14);
      t  = 102944 - ((z2 * t) >>> 14);
      s  = (x * t) >>> 14;
      p  = (s * TRIG_ONE) >>> 16;
      if (p > TRIG_ONE) p = TRIG_ONE;
      return p;
   endfunction

   function automatic longint angle_sine(logic [15:0] a);
      longint mag;
      if (a[14]) mag = quarter_sine(16384 - longint'(a[13:0]));
      else       mag = quarter_sine(longint'(a[13:0]));
      return a[15] ? -mag : mag;
   endfunction

   function automatic longint angle_cosine(logic [15:0] a);
      logic [15:0] shifted;
      shifted = a + dnt_pkg::QUARTER;
      return angle_sine(shifted);
   endfunction

   function automatic shade_type shade_pixel(pixel_type px);
      logic [31:0] lon_off, lat_off;
      logic [15:0] lon, lat, hour;
      longint      elev;
      shade_type   s;
      lon_off = (32'(px.col) * 32'(lon_step)) >> 8;
      lat_off = (32'(px.row) * 32'(lat_step)) >> 8;
      lon  = west + lon_off[15:0];
      lat  = north + lat_off[15:0];
      hour = sun_lon - lon;
      elev = angle_sine(sun_decl) * angle_sine(lat) * TRIG_ONE
           + angle_cosine(sun_decl) * angle_cosine(lat) * angle_cosine(hour);
      s.night       = (elev < 0);          // exactly zero counts as day
      s.mono_bit    = s.night ^ px.map_bit;
      s.color_pixel = s.night ? px.night_pixel : px.day_pixel;
      return s;
   endfunction

   // ---------------------------------------------------------------- drivers
   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   // one pixel beat; sender runs in bursts with random gaps between them
   task automatic send_pixel(pixel_type px);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tdata  = {px.night_pixel, px.day_pixel, px.map_bit, px.row, px.col};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      shade_queue.push_back(shade_pixel(px));
   endtask

   task automatic end_burst();
      @(negedge clock);
      req_tvalid = 1'b0;
      burst_left = 0;
   endtask

   task automatic drain();
      end_burst();
      wait (shade_queue.size() == 0);
      repeat (16) @(posedge clock);
   endtask

   // register write; only called with the pipeline empty
   task automatic write_reg(logic [2:0] index, logic [15:0] value);
      @(negedge clock);
      csr_index = index;
      csr_data  = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (index)
         dnt_pkg::REG_SUN_LON:  sun_lon  = value;
         dnt_pkg::REG_SUN_DECL: sun_decl = value;
         dnt_pkg::REG_WEST:     west     = value;
         dnt_pkg::REG_LON_STEP: lon_step = value;
         dnt_pkg::REG_NORTH:    north    = value;
         dnt_pkg::REG_LAT_STEP: lat_step = value;
         default: ;    // spare index, ignored by the block
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic load_all(logic [15:0] slon, logic [15:0] decl, logic [15:0] w,
                           logic [15:0] ls, logic [15:0] n, logic [15:0] as);
      write_reg(dnt_pkg::REG_SUN_LON, slon);
      write_reg(dnt_pkg::REG_SUN_DECL, decl);
      write_reg(dnt_pkg::REG_WEST, w);
      write_reg(dnt_pkg::REG_LON_STEP, ls);
      write_reg(dnt_pkg::REG_NORTH, n);
      write_reg(dnt_pkg::REG_LAT_STEP, as);
   endtask

   function automatic pixel_type random_pixel();
      pixel_type px;
      // mostly inside the map, some beyond it to exercise extrapolation
      if ($urandom_range(0, 4) != 0) begin
         px.col = 8'($urandom_range(0, 143));
         px.row = 7'($urandom_range(0, 99));
      end else begin
         px.col = 8'($urandom_range(0, 255));
         px.row = 7'($urandom_range(0, 127));
      end
      px.map_bit     = 1'($urandom_range(0, 1));
      px.day_pixel   = 8'($urandom_range(0, 255));
      px.night_pixel = 8'($urandom_range(0, 255));
      return px;
   endfunction

   function automatic pixel_type make_pixel(int c, int r, int m, int d, int n);
      pixel_type px;
      px.col = 8'(c); px.row = 7'(r); px.map_bit = 1'(m);
      px.day_pixel = 8'(d); px.night_pixel = 8'(n);
      return px;
   endfunction

   task automatic random_config();
      logic [15:0] decl;
      // declination mostly within a quarter circle, sometimes any pattern
      if ($urandom_range(0, 3) == 0) decl = 16'($urandom_range(0, 65535));
      else decl = 16'($signed($urandom_range(0, 32768)) - 16384);
      load_all(16'($urandom_range(0, 65535)), decl, 16'($urandom_range(0, 65535)),
               16'($urandom_range(0, 65535)),
               16'($signed($urandom_range(0, 32768)) - 16384),
               16'($urandom_range(0, 65535)));
   endtask

   // ---------------------------------------------------------------- tests
   // defaults after reset, field extremes, map edges and pixels beyond the map
   task automatic test_defaults_and_extremes();
      send_pixel(make_pixel(0, 0, 0, 8'h00, 8'hFF));
      send_pixel(make_pixel(143, 99, 1, 8'hFF, 8'h00));
      send_pixel(make_pixel(255, 127, 1, 8'hA5, 8'h5A));
      send_pixel(make_pixel(72, 50, 0, 8'h5A, 8'hA5));
      send_pixel(make_pixel(144, 100, 1, 8'h01, 8'h80));
      send_pixel(make_pixel(0, 127, 0, 8'h80, 8'h01));
      send_pixel(make_pixel(255, 0, 1, 8'h7F, 8'hFE));
      drain();
   endtask

   // spare csr indexes must leave every register alone
   task automatic test_spare_index();
      write_reg(SPARE_INDEX_A, 16'hFFFF);
      write_reg(SPARE_INDEX_B, 16'h1234);
      for (int i = 0; i < 6; i++) send_pixel(random_pixel());
      drain();
   endtask

   // sun at quarter-circle hour angle on the equator: elevation exactly zero is day
   task automatic test_zero_elevation();
      load_all(16'(16'd1000 + dnt_pkg::QUARTER), 16'd0, 16'd1000, 16'd0, 16'd0, 16'd0);
      send_pixel(make_pixel(0, 0, 0, 8'h11, 8'hEE));
      send_pixel(make_pixel(143, 99, 1, 8'h22, 8'hDD));
      drain();
      write_reg(dnt_pkg::REG_SUN_LON, 16'd1000 - dnt_pkg::QUARTER);
      send_pixel(make_pixel(7, 3, 1, 8'h33, 8'hCC));
      drain();
   endtask

   // register extremes: minimum, maximum and the declination limits
   task automatic test_register_extremes();
      logic [15:0] corner[4][6];
      corner[0] = '{16'd0, 16'hC000, 16'd0, 16'd0, 16'hC000, 16'd0};
      corner[1] = '{16'hFFFF, 16'h4000, 16'hFFFF, 16'hFFFF, 16'h4000, 16'hFFFF};
      corner[2] = '{16'h8000, 16'h8000, 16'h7FFF, 16'h0100, 16'h0000, 16'h0100};
      corner[3] = '{16'h0000, 16'h4000, 16'h8000, 16'h0000, 16'hC000, 16'h0000};
      for (int k = 0; k < 4; k++) begin
         load_all(corner[k][0], corner[k][1], corner[k][2],
                  corner[k][3], corner[k][4], corner[k][5]);
         send_pixel(make_pixel(0, 0, 1, 8'hFF, 8'h00));
         send_pixel(make_pixel(255, 127, 0, 8'h00, 8'hFF));
         send_pixel(random_pixel());
         drain();
      end
   endtask

   // bulk random pixels over a series of random settings
   task automatic test_random_sweep();
      for (int s = 0; s < 12; s++) begin
         random_config();
         repeat (100) send_pixel(random_pixel());
         drain();
      end
   endtask

   // receiver holds off long enough for the pipeline to fill and stall req
   task automatic test_backpressure();
      random_config();
      hold_off_cycles = 300;
      repeat (60) send_pixel(random_pixel());
      drain();
   endtask

   // ---------------------------------------------------------------- receiver
   // own stall pattern: phases of always ready, random, and periodic ready
   initial begin
      int phase_left, mode, tick;
      phase_left = 0; mode = 0; tick = 0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            rsp_tready = 1'b0;
         end else begin
            if (phase_left == 0) begin
               phase_left = $urandom_range(20, 200);
               mode = $urandom_range(0, 2);
            end
            phase_left--;
            tick++;
            case (mode)
               0: rsp_tready = 1'b1;
               1: rsp_tready = ($urandom_range(0, 9) < 6);
               default: rsp_tready = (tick % 4 != 0);
            endcase
         end
      end
   end

   // result checker, plus the stall watchdog
   initial begin
      shade_type want;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_valid)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (shade_queue.size() == 0) begin
               report_mismatch("unexpected beat", int'(rsp_tdata), 0);
            end else begin
               want = shade_queue.pop_front();
               if (rsp_tdata[0] !== want.night)
                  report_mismatch("night", int'(rsp_tdata[0]), int'(want.night));
               if (rsp_tdata[1] !== want.mono_bit)
                  report_mismatch("mono_bit", int'(rsp_tdata[1]), int'(want.mono_bit));
               if (rsp_tdata[9:2] !== want.color_pixel)
                  report_mismatch("color_pixel", int'(rsp_tdata[9:2]),
                                  int'(want.color_pixel));
               if (rsp_tdata[15:10] !== 6'd0)
                  report_mismatch("padding", int'(rsp_tdata[15:10]), 0);
            end
         end
      end
   end

   // ---------------------------------------------------------------- sequence
   initial begin
      sun_lon  = dnt_pkg::SUN_LON_RESET;
      sun_decl = dnt_pkg::SUN_DECL_RESET;
      west     = dnt_pkg::WEST_RESET;
      lon_step = dnt_pkg::LON_STEP_RESET;
      north    = dnt_pkg::NORTH_RESET;
      lat_step = dnt_pkg::LAT_STEP_RESET;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_defaults_and_extremes();
      test_spare_index();
      test_zero_elevation();
      test_register_extremes();
      test_backpressure();
      test_random_sweep();

      repeat (20) @(posedge clock);
      if (fail_count == 0 && shade_queue.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/dnt_pkg.sv
src/dnt_sine.sv
src/dnt_elev.sv
src/day_night_terminator_pixel_mask.sv
dv/tb_day_night_terminator_pixel_mask.sv
